/* hw/rtl/stt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;

  localparam logic [15:0] POS_ONE = 16'd1;
  localparam logic [15:0] POS_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_NUMBER  = 3'd0,
    KIND_STRING  = 3'd1,
    KIND_COMMENT = 3'd2,
    KIND_NEWLINE = 3'd3,
    KIND_SPACE   = 3'd4,
    KIND_END     = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] number_value;
    logic [7:0]  text_char;
    logic        char_valid;
    logic        last;
    logic        unterminated;
    logic [15:0] line;
    logic [15:0] column;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

  function automatic result_t make_result(kind_e kind, logic [63:0] value,
                                          logic [7:0] tc, logic vld, logic lst,
                                          logic unterm, logic [15:0] line,
                                          logic [15:0] column);
    result_t r;
    r.kind         = kind;
    r.number_value = value;
    r.text_char    = tc;
    r.char_valid   = vld;
    r.last         = lst;
    r.unterminated = unterm;
    r.line         = line;
    r.column       = column;
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/stt_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink (input valid, input ch, input end_of_input, output ready);
endinterface

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] number_value;
  logic [7:0]  text_char;
  logic        char_valid;
  logic        last;
  logic        unterminated;
  logic [15:0] line;
  logic [15:0] column;

  modport source (output valid, output kind, output number_value, output text_char,
                  output char_valid, output last, output unterminated, output line,
                  output column, input ready);
  modport sink (input valid, input kind, input number_value, input text_char,
                input char_valid, input last, input unterminated, input line,
                input column, output ready);
endinterface

`default_nettype wire

/* hw/rtl/stt_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module stt_core
  import stt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       take_i,
  input  wire logic [7:0] ch_i,
  input  wire logic       eoi_i,
  output push_t           push_o
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_STRING,
    MODE_SLASH,
    MODE_COMMENT
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [63:0] acc_q, acc_d;
  logic [15:0] line_q, line_d;
  logic [15:0] col_q, col_d;
  logic        seen_q, seen_d;

  logic        is_digit;
  logic [63:0] digit;
  logic [63:0] acc_next;
  logic [15:0] line_adv;
  logic [15:0] col_adv;
  logic        fall;
  logic        e0, e1;
  result_t     r0, r1;

  assign is_digit = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign digit    = {56'd0, 8'(ch_i - CH_ZERO)};
  assign acc_next = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0} + digit;

  always_comb begin
    if (ch_i == CH_NEWLINE) begin
      line_adv = (line_q != POS_MAX) ? 16'(line_q + POS_ONE) : line_q;
      col_adv  = POS_ONE;
    end else begin
      line_adv = line_q;
      col_adv  = (col_q != POS_MAX) ? 16'(col_q + POS_ONE) : col_q;
    end
  end

  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    line_d = line_q;
    col_d  = col_q;
    seen_d = seen_q;
    fall   = 1'b0;
    e0     = 1'b0;
    e1     = 1'b0;
    r0     = '0;
    r1     = '0;
    if (take_i) begin
      case (mode_q)
        MODE_NUMBER: begin
          if (!eoi_i && is_digit) begin
            acc_d  = acc_next;
            line_d = line_adv;
            col_d  = col_adv;
          end else begin
            r0     = make_result(KIND_NUMBER, acc_q, 8'd0, 1'b0, 1'b1, 1'b0, line_q, col_q);
            e0     = 1'b1;
            seen_d = 1'b1;
            mode_d = MODE_IDLE;
            fall   = 1'b1;
          end
        end
        MODE_STRING: begin
          if (eoi_i) begin
            r0     = make_result(KIND_STRING, 64'd0, 8'd0, 1'b0, 1'b1, 1'b1, line_q, col_q);
            e0     = 1'b1;
            seen_d = 1'b1;
            mode_d = MODE_IDLE;
            fall   = 1'b1;
          end else if (ch_i == CH_QUOTE) begin
            r0     = make_result(KIND_STRING, 64'd0, 8'd0, 1'b0, 1'b1, 1'b0,
                                 line_adv, col_adv);
            e0     = 1'b1;
            seen_d = 1'b1;
            mode_d = MODE_IDLE;
            line_d = line_adv;
            col_d  = col_adv;
          end else begin
            r0     = make_result(KIND_STRING, 64'd0, ch_i, 1'b1, 1'b0, 1'b0, line_q, col_q);
            e0     = 1'b1;
            line_d = line_adv;
            col_d  = col_adv;
          end
        end
        MODE_SLASH: begin
          mode_d = MODE_IDLE;
          if (!eoi_i && ch_i == CH_SLASH) begin
            r0     = make_result(KIND_COMMENT, 64'd0, ch_i, 1'b1, 1'b0, 1'b0, line_q, col_q);
            e0     = 1'b1;
            mode_d = MODE_COMMENT;
            line_d = line_adv;
            col_d  = col_adv;
          end else begin
            fall = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (eoi_i) begin
            r0     = make_result(KIND_COMMENT, 64'd0, 8'd0, 1'b0, 1'b1, 1'b0, line_q, col_q);
            e0     = 1'b1;
            seen_d = 1'b1;
            mode_d = MODE_IDLE;
            fall   = 1'b1;
          end else if (ch_i == CH_NEWLINE) begin
            r0     = make_result(KIND_COMMENT, 64'd0, 8'd0, 1'b0, 1'b1, 1'b0, line_q, col_q);
            e0     = 1'b1;
            seen_d = 1'b1;
            mode_d = MODE_IDLE;
            line_d = line_adv;
            col_d  = col_adv;
          end else begin
            r0     = make_result(KIND_COMMENT, 64'd0, ch_i, 1'b1, 1'b0, 1'b0, line_q, col_q);
            e0     = 1'b1;
            line_d = line_adv;
            col_d  = col_adv;
          end
        end
        default: begin
          mode_d = MODE_IDLE;
          fall   = 1'b1;
        end
      endcase

      if (fall) begin
        if (eoi_i) begin
          r1     = make_result(KIND_END, 64'd0, 8'd0, 1'b0, 1'b0, 1'b0, line_q, col_q);
          e1     = 1'b1;
          mode_d = MODE_IDLE;
          acc_d  = 64'd0;
          line_d = POS_ONE;
          col_d  = POS_ONE;
          seen_d = 1'b0;
        end else begin
          if (is_digit) begin
            acc_d  = digit;
            mode_d = MODE_NUMBER;
          end else if (ch_i == CH_QUOTE) begin
            mode_d = MODE_STRING;
          end else if (ch_i == CH_SLASH) begin
            mode_d = MODE_SLASH;
          end else if (ch_i == CH_NEWLINE) begin
            r1     = make_result(KIND_NEWLINE, 64'd0, 8'd0, 1'b0, 1'b1, 1'b0, line_q, col_q);
            e1     = 1'b1;
            seen_d = 1'b1;
          end else if ((ch_i == CH_SPACE || ch_i == CH_TAB) && seen_d) begin
            r1 = make_result(KIND_SPACE, 64'd0, 8'd0, 1'b0, 1'b0, 1'b0, line_q, col_q);
            e1 = 1'b1;
          end
          line_d = line_adv;
          col_d  = col_adv;
        end
      end
    end
  end

  always_comb begin
    if (e0) begin
      push_o.res0  = r0;
      push_o.res1  = r1;
      push_o.count = e1 ? 2'd2 : 2'd1;
    end else begin
      push_o.res0  = r1;
      push_o.res1  = r1;
      push_o.count = e1 ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      acc_q  <= 64'd0;
      line_q <= POS_ONE;
      col_q  <= POS_ONE;
      seen_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      line_q <= line_d;
      col_q  <= col_d;
      seen_q <= seen_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/stt_result_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module stt_result_queue
  import stt_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  output logic       room_o,
  stt_out_if.source  out_o
);

  localparam int unsigned Depth = 3;

  result_t    ent_q [Depth];
  result_t    ent_d [Depth];
  logic [1:0] count_q, count_d;
  logic [1:0] base;
  logic       pop;

  assign pop    = (count_q != 2'd0) && out_o.ready;
  assign base   = pop ? 2'(count_q - 2'd1) : count_q;
  assign room_o = (count_q <= 2'd1);

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (pop && i < Depth - 1) begin
        ent_d[i] = ent_q[i + 1];
      end else begin
        ent_d[i] = ent_q[i];
      end
      if (push_i.count != 2'd0 && 2'(i) == base) begin
        ent_d[i] = push_i.res0;
      end
      if (push_i.count == 2'd2 && 2'(i) == 2'(base + 2'd1)) begin
        ent_d[i] = push_i.res1;
      end
    end
    count_d = 2'(base + push_i.count);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  assign out_o.valid        = (count_q != 2'd0);
  assign out_o.kind         = ent_q[0].kind;
  assign out_o.number_value = ent_q[0].number_value;
  assign out_o.text_char    = ent_q[0].text_char;
  assign out_o.char_valid   = ent_q[0].char_valid;
  assign out_o.last         = ent_q[0].last;
  assign out_o.unterminated = ent_q[0].unterminated;
  assign out_o.line         = ent_q[0].line;
  assign out_o.column       = ent_q[0].column;

endmodule

`default_nettype wire

/* hw/rtl/source_text_tokenizer_unit.sv */
// A request waits in the input register until the queue has room; its results are then
// registered in the queue. Throughput: one request per cycle while the output is ready; a
// two-result request stalls the input while the single-result port drains the 3-entry queue.
// Reset: asynchronous, active low; lexer mode idle, value 0, line and column 1, queue empty.
`timescale 1ns / 1ps
`default_nettype none

module source_text_tokenizer_unit
  import stt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  stt_in_if.sink    in_i,
  stt_out_if.source out_o
);

  logic       in_vld_q;
  logic [7:0] in_ch_q;
  logic       in_eoi_q;
  logic       room;
  logic       take;
  push_t      push;

  assign take       = in_vld_q && room;
  assign in_i.ready = !in_vld_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (take) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_ch_q  <= in_i.ch;
      in_eoi_q <= in_i.end_of_input;
    end
  end

  stt_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .ch_i   (in_ch_q),
    .eoi_i  (in_eoi_q),
    .push_o (push)
  );

  stt_result_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

  a_push_needs_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.count != 2'd0 |-> take)
    else $error("results pushed without a request taken");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.count != 2'd3)
    else $error("more than two results for one request");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.count == 2'd2 |-> push.res0.last && push.res0.kind != KIND_END)
    else $error("first of a result pair is not a closing token item");

  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.count != 2'd0 |=> out_o.valid)
    else $error("pushed result left the result queue empty");

endmodule

`default_nettype wire

/* test/source_text_tokenizer_unit_tb.sv */
`timescale 1ns / 1ps

module source_text_tokenizer_unit_tb;
  import stt_pkg::*;

  localparam int RANDOM_CHARS = 1350;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef enum logic [2:0] {
    LEX_IDLE,
    LEX_NUMBER,
    LEX_STRING,
    LEX_SLASH,
    LEX_COMMENT
  } lex_mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } src_char_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  stt_in_if  in_bus ();
  stt_out_if out_bus ();

  source_text_tokenizer_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  lex_mode_e   lex_mode;
  logic [63:0] digit_acc;
  logic [15:0] cur_line;
  logic [15:0] cur_col;
  bit          token_seen;

  result_t   expected_tokens[$];
  src_char_t pending_chars[$];

  int chars_queued   = 0;
  int chars_taken    = 0;
  int tokens_checked = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int gap_left       = 0;
  int wait_left      = 0;
  int hold_left      = 0;
  bit hold_used      = 1'b0;
  int drv_stretch    = 0;
  int mon_stretch    = 0;
  bit drv_busy       = 1'b0;
  bit mon_busy       = 1'b0;

  function automatic void reset_lexer();
    lex_mode   = LEX_IDLE;
    digit_acc  = '0;
    cur_line   = POS_ONE;
    cur_col    = POS_ONE;
    token_seen = 1'b0;
  endfunction

  function automatic void advance_pos(logic [7:0] c);
    if (c == CH_NEWLINE) begin
      if (cur_line != POS_MAX) cur_line++;
      cur_col = POS_ONE;
    end else if (cur_col != POS_MAX) begin
      cur_col++;
    end
  endfunction

  function automatic void push_token(kind_e k, logic [63:0] v, logic [7:0] tc, logic vld,
                                     logic lst, logic unt);
    result_t r;
    r.kind         = k;
    r.number_value = v;
    r.text_char    = tc;
    r.char_valid   = vld;
    r.last         = lst;
    r.unterminated = unt;
    r.line         = cur_line;
    r.column       = cur_col;
    expected_tokens.push_back(r);
  endfunction

  function automatic void tokenize_char(logic [7:0] c, logic eoi);
    bit is_digit;
    is_digit = !eoi && c >= CH_ZERO && c <= CH_NINE;
    case (lex_mode)
      LEX_NUMBER: begin
        if (is_digit) begin
          digit_acc = digit_acc * 64'd10 + {56'd0, c - CH_ZERO};
          advance_pos(c);
          return;
        end
        push_token(KIND_NUMBER, digit_acc, 8'h00, 1'b0, 1'b1, 1'b0);
        token_seen = 1'b1;
        lex_mode   = LEX_IDLE;
      end
      LEX_STRING: begin
        if (eoi) begin
          push_token(KIND_STRING, '0, 8'h00, 1'b0, 1'b1, 1'b1);
          token_seen = 1'b1;
          lex_mode   = LEX_IDLE;
        end else if (c == CH_QUOTE) begin
          advance_pos(c);
          push_token(KIND_STRING, '0, 8'h00, 1'b0, 1'b1, 1'b0);
          token_seen = 1'b1;
          lex_mode   = LEX_IDLE;
          return;
        end else begin
          push_token(KIND_STRING, '0, c, 1'b1, 1'b0, 1'b0);
          advance_pos(c);
          return;
        end
      end
      LEX_SLASH: begin
        lex_mode = LEX_IDLE;
        if (!eoi && c == CH_SLASH) begin
          push_token(KIND_COMMENT, '0, c, 1'b1, 1'b0, 1'b0);
          advance_pos(c);
          lex_mode = LEX_COMMENT;
          return;
        end
      end
      LEX_COMMENT: begin
        if (eoi) begin
          push_token(KIND_COMMENT, '0, 8'h00, 1'b0, 1'b1, 1'b0);
          token_seen = 1'b1;
          lex_mode   = LEX_IDLE;
        end else if (c == CH_NEWLINE) begin
          push_token(KIND_COMMENT, '0, 8'h00, 1'b0, 1'b1, 1'b0);
          token_seen = 1'b1;
          advance_pos(c);
          lex_mode = LEX_IDLE;
          return;
        end else begin
          push_token(KIND_COMMENT, '0, c, 1'b1, 1'b0, 1'b0);
          advance_pos(c);
          return;
        end
      end
      default: begin
        lex_mode = LEX_IDLE;
      end
    endcase

    if (eoi) begin
      push_token(KIND_END, '0, 8'h00, 1'b0, 1'b0, 1'b0);
      reset_lexer();
      return;
    end

    if (is_digit) begin
      digit_acc = {56'd0, c - CH_ZERO};
      lex_mode  = LEX_NUMBER;
    end else if (c == CH_QUOTE) begin
      lex_mode = LEX_STRING;
    end else if (c == CH_SLASH) begin
      lex_mode = LEX_SLASH;
    end else if (c == CH_NEWLINE) begin
      push_token(KIND_NEWLINE, '0, 8'h00, 1'b0, 1'b1, 1'b0);
      token_seen = 1'b1;
    end else if ((c == CH_SPACE || c == CH_TAB) && token_seen) begin
      push_token(KIND_SPACE, '0, 8'h00, 1'b0, 1'b0, 1'b0);
    end
    advance_pos(c);
  endfunction

  function automatic int pause_cycles(inout int stretch, inout bit busy);
    if (stretch == 0) begin
      stretch = $urandom_range(8, 64);
      busy    = $urandom_range(0, 2) != 0;
    end
    stretch--;
    return busy ? int'($urandom_range(0, 16)) : 0;
  endfunction

  function automatic string token_text(result_t r);
    return $sformatf("kind %0d value %0d char %02h valid %0b last %0b unterm %0b line %0d col %0d",
                     r.kind, r.number_value, r.text_char, r.char_valid, r.last,
                     r.unterminated, r.line, r.column);
  endfunction

  function automatic void queue_char(logic [7:0] c, logic e);
    src_char_t s;
    s.ch  = c;
    s.eoi = e;
    pending_chars.push_back(s);
    chars_queued++;
  endfunction

  task automatic wait_drained();
    while (chars_taken != chars_queued || expected_tokens.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : drive_chars
    src_char_t nxt;
    if (!rst_ni) begin
      in_bus.valid        <= 1'b0;
      in_bus.ch           <= 8'h00;
      in_bus.end_of_input <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        tokenize_char(in_bus.ch, in_bus.end_of_input);
        chars_taken++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          nxt = pending_chars.pop_front();
          in_bus.valid        <= 1'b1;
          in_bus.ch           <= nxt.ch;
          in_bus.end_of_input <= nxt.eoi;
          gap_left = pause_cycles(drv_stretch, drv_busy);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_tokens
    result_t got;
    result_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      wait_left = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.kind         = kind_e'(out_bus.kind);
        got.number_value = out_bus.number_value;
        got.text_char    = out_bus.text_char;
        got.char_valid   = out_bus.char_valid;
        got.last         = out_bus.last;
        got.unterminated = out_bus.unterminated;
        got.line         = out_bus.line;
        got.column       = out_bus.column;
        if (expected_tokens.size() == 0) begin
          if (mismatch_count < 10) $display("unexpected result: %s", token_text(got));
          mismatch_count++;
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10)
              $display("result %0d mismatch\n  expected %s\n  actual   %s",
                       tokens_checked, token_text(want), token_text(got));
            mismatch_count++;
          end
        end
        tokens_checked <= tokens_checked + 1;
        wait_left = pause_cycles(mon_stretch, mon_busy);
      end else if (wait_left > 0) begin
        wait_left--;
      end
      out_bus.ready <= wait_left == 0 && hold_left == 0;
    end
  end

  // hold the output once for a long stretch so the block backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (!hold_used && tokens_checked >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  initial begin : run_stimulus
    string      wide_numbers [2];
    string      digits;
    int         pick;
    int         len;
    logic [7:0] b;

    in_bus.valid        = 1'b0;
    in_bus.ch           = 8'h00;
    in_bus.end_of_input = 1'b0;
    out_bus.ready       = 1'b0;
    rst_ni              = 1'b0;
    reset_lexer();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    queue_char(CH_SPACE, 1'b0);
    queue_char(8'hFF, 1'b0);
    queue_char(CH_ZERO, 1'b0);
    queue_char(CH_NINE, 1'b0);
    queue_char(CH_TAB, 1'b0);
    queue_char(CH_SLASH, 1'b0);
    queue_char(CH_QUOTE, 1'b0);
    queue_char(8'hFF, 1'b0);
    queue_char(CH_NEWLINE, 1'b0);
    queue_char(CH_QUOTE, 1'b0);
    queue_char(CH_SPACE, 1'b0);
    queue_char(CH_SLASH, 1'b0);
    queue_char(CH_SLASH, 1'b0);
    queue_char(8'h00, 1'b0);
    queue_char(CH_NEWLINE, 1'b0);
    queue_char(CH_NEWLINE, 1'b0);
    queue_char(8'h34, 1'b0);
    queue_char(8'hFF, 1'b1);
    queue_char(CH_QUOTE, 1'b0);
    queue_char(8'h37, 1'b0);
    queue_char(8'h00, 1'b1);
    queue_char(CH_SLASH, 1'b0);
    queue_char(CH_SLASH, 1'b0);
    queue_char(8'h80, 1'b1);
    queue_char(CH_SLASH, 1'b0);
    queue_char(8'h7F, 1'b1);

    wide_numbers[0] = "18446744073709551615";
    wide_numbers[1] = "18446744073709551616";
    foreach (wide_numbers[n]) begin
      digits = wide_numbers[n];
      for (int i = 0; i < digits.len(); i++) queue_char(digits[i], 1'b0);
      queue_char(CH_SPACE, 1'b0);
    end

    while (chars_queued < RANDOM_CHARS) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 4);
        repeat (len) begin
          b = 8'($urandom_range(0, 9));
          queue_char(CH_ZERO + b, 1'b0);
        end
      end else if (pick < 40) begin
        queue_char(CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 6)) begin
          b = 8'($urandom_range(0, 255));
          if (b == CH_QUOTE) b ^= 8'h01;
          queue_char(b, 1'b0);
        end
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) != 0) queue_char(CH_QUOTE, 1'b0);
        else queue_char(b, 1'b1);
      end else if (pick < 55) begin
        queue_char(CH_SLASH, 1'b0);
        queue_char(CH_SLASH, 1'b0);
        repeat ($urandom_range(0, 6)) begin
          b = 8'($urandom_range(0, 255));
          if (b == CH_NEWLINE) b ^= 8'h01;
          queue_char(b, 1'b0);
        end
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 6) != 0) queue_char(CH_NEWLINE, 1'b0);
        else queue_char(b, 1'b1);
      end else if (pick < 67) begin
        queue_char(CH_NEWLINE, 1'b0);
      end else if (pick < 79) begin
        repeat ($urandom_range(1, 3)) queue_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
      end else if (pick < 85) begin
        queue_char(CH_SLASH, 1'b0);
      end else if (pick < 96) begin
        b = 8'($urandom_range(0, 255));
        queue_char(b, 1'b0);
      end else begin
        b = 8'($urandom_range(0, 255));
        queue_char(b, 1'b1);
      end
    end

    wait_drained();

    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/stt_pkg.sv
hw/rtl/stt_if.sv
hw/rtl/stt_core.sv
hw/rtl/stt_result_queue.sv
hw/rtl/source_text_tokenizer_unit.sv
test/source_text_tokenizer_unit_tb.sv
